// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the note sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset, reporting a fixed message.
`define MNS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("note sequencer check failed");

// Implication held on every clock edge out of reset.
`define MNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("note sequencer implication failed");

`endif

// File: rtl/mns_pkg.sv
// Types and constants shared by the melody note sequencer modules.
package mns_pkg;

  localparam int REQ_W      = 3;
  localparam int SLOT_W     = 6;
  localparam int FREQ_W     = 16;
  localparam int DUR_W      = 16;
  localparam int ACT_W      = 2;
  localparam int POS_W      = 7;
  localparam int LEN_W      = 7;
  localparam int REP_W      = 16;
  localparam int WORD_W     = FREQ_W + DUR_W;
  localparam int TDATA_W    = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [REP_W-1:0] REPEAT_ALL  = 16'hFFFF;

  // Request codes on the input tuser.
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PLAY   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESUME = 3'd4;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd5;

  // Tone action codes on the output tuser.
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MELODY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_LOAD,
    CMD_PLAY,
    CMD_PAUSE,
    CMD_RESUME,
    CMD_STOP
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } q_item_t;

endpackage

// File: rtl/mns_front.sv
// Front end: accept requests, classify them, and queue them for the back end.
module mns_front #(
  parameter int MAX_NOTES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: note_slot[5:0], note_frequency[21:6], note_duration[37:22], zero fill
  input  logic [mns_pkg::TDATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[2:0]
  input  logic [mns_pkg::REQ_W-1:0]    s_axis_tuser,
  output mns_pkg::q_item_t             item_o,
  output logic                         item_valid_o,
  input  logic                         item_ready_i
);
  import mns_pkg::*;

  q_item_t    cls_item;
  q_item_t    slots_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    cls_item.slot = s_axis_tdata[SLOT_W-1:0];
    cls_item.freq = s_axis_tdata[SLOT_W +: FREQ_W];
    cls_item.dur  = s_axis_tdata[SLOT_W+FREQ_W +: DUR_W];
    case (s_axis_tuser)
      REQ_TICK:   cls_item.cmd = CMD_TICK;
      // drop loads aimed past the table
      REQ_LOAD:   cls_item.cmd = (32'(cls_item.slot) < MAX_NOTES) ? CMD_LOAD : CMD_NOP;
      REQ_PLAY:   cls_item.cmd = CMD_PLAY;
      REQ_PAUSE:  cls_item.cmd = CMD_PAUSE;
      REQ_RESUME: cls_item.cmd = CMD_RESUME;
      REQ_STOP:   cls_item.cmd = CMD_STOP;
      default:    cls_item.cmd = CMD_NOP;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = slots_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

// File: rtl/mns_back.sv
// Back end: note table, playback state, and the registered result stage.
module mns_back #(
  parameter int MAX_NOTES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mns_pkg::q_item_t            item_i,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  logic [mns_pkg::LEN_W-1:0]   melody_length_i,
  input  logic [mns_pkg::REP_W-1:0]   repeat_count_i,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: tone_frequency[15:0], tone_duration[31:16], is_playing[32],
  //        note_position[39:33]
  output logic [mns_pkg::TDATA_W-1:0] m_axis_tdata,
  // tuser: tone_action[1:0]
  output logic [mns_pkg::ACT_W-1:0]   m_axis_tuser
);
  import mns_pkg::*;

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  logic [WORD_W-1:0] mem_q [MAX_NOTES];
  logic [WORD_W-1:0] rd_next_q, rd_prev_q, byp_data_q;
  logic              byp_next_q, byp_prev_q;
  logic [WORD_W-1:0] cur_word, prev_word;

  logic [POS_W-1:0]  next_note_q, next_note_d;
  logic [DUR_W-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic [REP_W-1:0]  repeats_q, repeats_d;
  logic              forever_q, forever_d;
  logic              play_q, play_d;

  logic              out_valid_q, out_valid_d;
  logic [ACT_W-1:0]  out_act_q;
  logic [TDATA_W-1:0] out_data_q;

  logic [ACT_W-1:0]  res_act;
  logic [FREQ_W-1:0] res_freq;
  logic [DUR_W-1:0]  res_dur;

  logic              pop, wr_en;
  logic [LEN_W-1:0]  len;
  logic [31:0]       nn_wide, pv_wide, slot_wide;
  logic [IDX_W-1:0]  ra_next, ra_prev, wa;
  logic [WORD_W-1:0] wd;

  assign item_ready_o = !out_valid_q || m_axis_tready;
  assign pop          = item_valid_i && item_ready_o;
  assign wr_en        = pop && (item_i.cmd == CMD_LOAD);

  // Clamp the live length to the table size.
  assign len = (32'(melody_length_i) > MAX_NOTES) ? LEN_W'(MAX_NOTES) : melody_length_i;

  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

  // Read ports follow the next position so the data lines up with next_note_q.
  assign nn_wide   = 32'(next_note_d);
  assign pv_wide   = (next_note_d != '0) ? 32'(next_note_d - 7'd1) : 32'd0;
  assign slot_wide = 32'(item_i.slot);
  assign ra_next   = nn_wide[IDX_W-1:0];
  assign ra_prev   = pv_wide[IDX_W-1:0];
  assign wa        = slot_wide[IDX_W-1:0];
  assign wd        = {item_i.freq, item_i.dur};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wa] <= wd;
    end
    rd_next_q  <= mem_q[ra_next];
    rd_prev_q  <= mem_q[ra_prev];
    byp_next_q <= wr_en && (wa == ra_next);
    byp_prev_q <= wr_en && (wa == ra_prev);
    byp_data_q <= wd;
  end

  assign cur_word  = byp_next_q ? byp_data_q : rd_next_q;
  assign prev_word = byp_prev_q ? byp_data_q : rd_prev_q;

  always_comb begin
    next_note_d = next_note_q;
    elapsed_d   = elapsed_q;
    repeats_d   = repeats_q;
    forever_d   = forever_q;
    play_d      = play_q;
    res_act     = ACT_NONE;
    res_freq    = '0;
    res_dur     = '0;
    if (pop) begin
      case (item_i.cmd)
        CMD_TICK: begin
          elapsed_d = elapsed_inc;
          if (play_q) begin
            if (repeats_q != '0) begin
              if (elapsed_inc >= prev_word[DUR_W-1:0]) begin
                if (next_note_q < len) begin
                  elapsed_d   = '0;
                  next_note_d = next_note_q + 7'd1;
                  if (cur_word[WORD_W-1:DUR_W] != '0) begin
                    res_act  = ACT_START;
                    res_freq = cur_word[WORD_W-1:DUR_W];
                    res_dur  = cur_word[DUR_W-1:0];
                  end
                end else begin
                  // end of table: stop tone, rewind, count a pass unless repeating forever
                  res_act     = ACT_STOP;
                  next_note_d = '0;
                  if (!forever_q) begin
                    repeats_d = repeats_q - 16'd1;
                  end
                end
              end
            end else begin
              res_act     = ACT_STOP;
              play_d      = 1'b0;
              repeats_d   = '0;
              next_note_d = '0;
              forever_d   = 1'b0;
            end
          end
        end
        CMD_PLAY: begin
          play_d      = 1'b1;
          next_note_d = '0;
          elapsed_d   = ELAPSED_MAX;
          if (repeat_count_i != '0) begin
            repeats_d = repeat_count_i;
            forever_d = 1'b0;
          end else begin
            repeats_d = REPEAT_ALL;
            forever_d = 1'b1;
          end
        end
        CMD_PAUSE:  play_d = 1'b0;
        CMD_RESUME: play_d = 1'b1;
        CMD_STOP: begin
          res_act     = ACT_STOP;
          play_d      = 1'b0;
          repeats_d   = '0;
          next_note_d = '0;
          forever_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_note_q <= '0;
      elapsed_q   <= '0;
      repeats_q   <= '0;
      forever_q   <= 1'b0;
      play_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      next_note_q <= next_note_d;
      elapsed_q   <= elapsed_d;
      repeats_q   <= repeats_d;
      forever_q   <= forever_d;
      play_q      <= play_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_act_q  <= res_act;
      out_data_q <= {next_note_d, play_d, res_dur, res_freq};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_act_q;

endmodule

// File: rtl/melody_note_sequencer_top.sv
// Top level of the melody note sequencer: config registers, front and back ends.
//
// Usage:
//   s_axis carries requests: tuser is the request kind (tick, load note, play,
//   pause, resume, stop), tdata holds slot, frequency and duration. Each tick
//   stands for one millisecond. Every accepted request yields exactly one
//   result transfer on m_axis: tuser is the tone action (none, start, stop),
//   tdata holds tone frequency, tone duration, playing flag and note position.
//   Write melody_length (index 0) and repeat_count (index 1) through the cfg
//   port only while no request is in flight.
// Timing:
//   A request is first registered in the front queue and then in the result
//   stage. One request per cycle is sustained while m_axis_tready stays high;
//   the note table has two registered read ports steered by the next position,
//   so the duration check and the next-note fetch never wait on the memory.
// Reset:
//   Playback stops, position, timer and repeats clear, melody_length goes to
//   0 and repeat_count to 1. The note table keeps no reset; load notes first.
// Back-pressure:
//   When m_axis_tready is low the result is held and a two-entry queue
//   between front and back keeps taking requests until it fills.
module melody_note_sequencer_top #(
  parameter int MAX_NOTES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: note_slot[5:0], note_frequency[21:6], note_duration[37:22], zero fill
  input  logic [mns_pkg::TDATA_W-1:0]      s_axis_tdata,
  // tuser: req_type[2:0]
  input  logic [mns_pkg::REQ_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: tone_frequency[15:0], tone_duration[31:16], is_playing[32],
  //        note_position[39:33]
  output logic [mns_pkg::TDATA_W-1:0]      m_axis_tdata,
  // tuser: tone_action[1:0]
  output logic [mns_pkg::ACT_W-1:0]        m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [mns_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mns_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mns_pkg::*;

  logic [LEN_W-1:0] melody_length_q;
  logic [REP_W-1:0] repeat_count_q;
  q_item_t          q_item;
  logic             q_valid, q_ready;

  // Config registers: take a write whenever the enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      melody_length_q <= '0;
      repeat_count_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MELODY_LENGTH: melody_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_REPEAT_COUNT:  repeat_count_q  <= cfg_data_i[REP_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify and queue incoming requests.
  mns_front #(
    .MAX_NOTES(MAX_NOTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .item_o       (q_item),
    .item_valid_o (q_valid),
    .item_ready_i (q_ready)
  );

  // Execute requests against the note table and playback state.
  mns_back #(
    .MAX_NOTES(MAX_NOTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (q_item),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .melody_length_i(melody_length_q),
    .repeat_count_i (repeat_count_q),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser)
  );

endmodule

// File: rtl/mns_checker.sv
// Port-level checks for the melody note sequencer, bound to the top level.
`include "assert_macros.svh"

module mns_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mns_pkg::TDATA_W-1:0]    m_axis_tdata,
  input logic [mns_pkg::ACT_W-1:0]      m_axis_tuser
);
  import mns_pkg::*;

  logic stalled;
  logic not_start;

  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign not_start = m_axis_tvalid && (m_axis_tuser != ACT_START);

  // A stalled result stays offered and its tdata unchanged.
  `MNS_ASSERT_IMPL(a_hold_valid, clk_i, rst_ni, stalled, ##1 m_axis_tvalid)
  `MNS_ASSERT_IMPL(a_hold_data, clk_i, rst_ni, stalled, ##1 $stable(m_axis_tdata))
  // Frequency and duration are zero unless a tone starts.
  `MNS_ASSERT_IMPL(a_idle_zero, clk_i, rst_ni, not_start, m_axis_tdata[31:0] == 32'd0)
  // A started tone means playing and a position past note zero.
  `MNS_ASSERT_IMPL(a_start_play, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == ACT_START),
    m_axis_tdata[32] && (m_axis_tdata[39:33] != 7'd0))

endmodule

bind melody_note_sequencer_top mns_checker u_mns_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
